// ----- rtl/core/twc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helpers for the textured wall column texel generator.
// No dependencies.
package twc_pkg;

    localparam int SCREEN_WIDTH  = 1024;
    localparam int SCREEN_HEIGHT = 1024;
    localparam int FRAC_BITS     = 16;

    localparam int COORD_W    = 10;
    localparam int TEX_DIM_W  = 11;
    localparam int TEX_DIM_MAX = 1024;
    localparam int LH_W       = 16;
    localparam int RAY_W      = 21;
    localparam int POS_W      = 24;
    localparam int DIST_W     = 24;
    localparam int CFG_IDX_W  = 3;

    localparam int S_TDATA_W  = 168;
    localparam int M_TDATA_W  = 48;

    // Signed row offset: row*256 - SCREEN_HEIGHT*128 + lh*128
    localparam int ROW_OFF_W  = 26;
    localparam int MAG_W      = ROW_OFF_W - 1;
    localparam int DIV_STEPS  = TEX_DIM_W;
    localparam int NUM_W      = MAG_W + TEX_DIM_W;
    localparam int REM_W      = NUM_W - DIV_STEPS;
    localparam int DSR_W      = LH_W + 8;
    localparam int CNT_W      = $clog2(DIV_STEPS + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic OP_SETUP = 1'b0;
    localparam logic OP_ROW   = 1'b1;

    localparam logic [1:0] TEX_WEST  = 2'd0;
    localparam logic [1:0] TEX_EAST  = 2'd1;
    localparam logic [1:0] TEX_NORTH = 2'd2;
    localparam logic [1:0] TEX_SOUTH = 2'd3;

    typedef struct packed {
        logic [COORD_W-1:0]          screen_x;
        logic [COORD_W-1:0]          screen_y;
        logic [1:0]                  tex_sel;
        logic [COORD_W-1:0]          texel_x;
        logic [TEX_DIM_W-1:0]        tex_h;
        logic [LH_W-1:0]             line_h;
        logic signed [ROW_OFF_W-1:0] row_off;
        logic                        last;
    } job_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL,
        F_ADD,
        F_SCALE,
        F_FIN
    } f_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL,
        B_CHK,
        B_DIV,
        B_CLAMP,
        B_OUT
    } b_state_t;

    function automatic logic [TEX_DIM_W-1:0] tex_dim(input logic [TEX_DIM_W-1:0] v);
        logic [TEX_DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = TEX_DIM_W'(1);
        end else if (v > TEX_DIM_W'(TEX_DIM_MAX)) begin
            r = TEX_DIM_W'(TEX_DIM_MAX);
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/twc_queue.sv -----
`timescale 1ns / 1ps
// Short job queue between the front and back parts.
// Depends on twc_pkg (job_t, QUEUE_DEPTH).
module twc_queue import twc_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t pop_job,
    output logic empty
);

    job_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;

    assign full    = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign pop_job = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- rtl/core/twc_front.sv -----
`timescale 1ns / 1ps
// Front part: texture registers, column setup pipeline and row tick issue.
// Depends on twc_pkg; feeds twc_queue with row jobs.
module twc_front import twc_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tuser,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [TEX_DIM_W-1:0]  cfg_data,
    output logic                  q_push,
    output job_t                  q_job,
    input  logic                  q_full
);

    f_state_t state_reg, state_next;

    logic [TEX_DIM_W-1:0] tex_w_reg [4];
    logic [TEX_DIM_W-1:0] tex_h_reg [4];

    logic [COORD_W-1:0] active_column_reg;
    logic [1:0]         chosen_texture_reg;
    logic [COORD_W-1:0] column_texel_reg;
    logic [LH_W-1:0]    held_line_height_reg;
    logic [COORD_W-1:0] current_row_reg;
    logic [COORD_W-1:0] final_row_reg;
    logic               span_active_reg;

    logic [DIST_W-1:0]        dist_reg;
    logic signed [RAY_W-1:0]  ray_reg;
    logic [FRAC_BITS-1:0]     pos_lo_reg;
    logic [TEX_DIM_W-1:0]     w_reg;
    logic                     mirror_reg;
    logic [2*FRAC_BITS-1:0]   prod_reg;
    logic [2*FRAC_BITS-1:0]   wall_reg;
    logic [COORD_W-1:0]       tx_raw_reg;

    logic                     s_fire;
    logic [COORD_W-1:0]       in_column;
    logic                     in_side;
    logic signed [RAY_W-1:0]  in_rx;
    logic signed [RAY_W-1:0]  in_ry;
    logic [POS_W-1:0]         in_px;
    logic [POS_W-1:0]         in_py;
    logic [DIST_W-1:0]        in_dist;
    logic [LH_W-1:0]          in_lh;
    logic [COORD_W-1:0]       in_s0;
    logic [COORD_W-1:0]       in_s1;

    logic [1:0]               sel;
    logic                     mirror;
    logic [COORD_W-1:0]       s1_sat;
    logic signed [DIST_W+RAY_W:0] product;
    logic [2*FRAC_BITS+TEX_DIM_W-1:0] scaled;
    logic [TEX_DIM_W-1:0]     tx_m;
    logic [TEX_DIM_W-1:0]     tx_fin;
    logic                     row_fire;

    assign in_column = s_tdata[9:0];
    assign in_side   = s_tdata[10];
    assign in_rx     = s_tdata[31:11];
    assign in_ry     = s_tdata[52:32];
    assign in_px     = s_tdata[76:53];
    assign in_py     = s_tdata[100:77];
    assign in_dist   = s_tdata[124:101];
    assign in_lh     = s_tdata[140:125];
    assign in_s0     = s_tdata[150:141];
    assign in_s1     = s_tdata[160:151];

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == F_IDLE) && !q_full;
    assign s_fire    = s_tvalid && s_tready;
    assign row_fire  = s_fire && (s_tuser == OP_ROW) && span_active_reg;

    always_comb begin
        if (!in_side) begin
            sel = in_rx[RAY_W-1] ? TEX_WEST : TEX_EAST;
        end else begin
            sel = in_ry[RAY_W-1] ? TEX_NORTH : TEX_SOUTH;
        end
    end

    assign mirror = (!in_side && in_rx[RAY_W-1])
                 || (in_side && !in_ry[RAY_W-1] && (in_ry != '0));
    assign s1_sat = ({2'b0, in_s1} > 12'(SCREEN_HEIGHT - 1))
                  ? COORD_W'(SCREEN_HEIGHT - 1) : in_s1;

    assign product = $signed({1'b0, dist_reg}) * ray_reg;
    assign scaled  = (2*FRAC_BITS+TEX_DIM_W)'(wall_reg)
                   * (2*FRAC_BITS+TEX_DIM_W)'(w_reg);
    assign tx_m    = mirror_reg ? (w_reg - {1'b0, tx_raw_reg} - 1'b1)
                                : {1'b0, tx_raw_reg};
    assign tx_fin  = (tx_m >= w_reg) ? (w_reg - 1'b1) : tx_m;

    always_comb begin
        q_push           = row_fire;
        q_job.screen_x   = active_column_reg;
        q_job.screen_y   = current_row_reg;
        q_job.tex_sel    = chosen_texture_reg;
        q_job.texel_x    = column_texel_reg;
        q_job.tex_h      = tex_dim(tex_h_reg[chosen_texture_reg]);
        q_job.line_h     = held_line_height_reg;
        q_job.row_off    = (ROW_OFF_W'(current_row_reg) << 8)
                         + (ROW_OFF_W'(held_line_height_reg) << 7)
                         - ROW_OFF_W'(SCREEN_HEIGHT * 128);
        q_job.last       = (current_row_reg >= final_row_reg);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: begin
                if (s_fire && (s_tuser == OP_SETUP)) begin
                    state_next = F_MUL;
                end
            end
            F_MUL:   state_next = F_ADD;
            F_ADD:   state_next = F_SCALE;
            F_SCALE: state_next = F_FIN;
            F_FIN:   state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                tex_w_reg[i] <= TEX_DIM_W'(64);
                tex_h_reg[i] <= TEX_DIM_W'(64);
            end
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index[0]) begin
                tex_h_reg[cfg_index[2:1]] <= cfg_data;
            end else begin
                tex_w_reg[cfg_index[2:1]] <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_column_reg    <= '0;
            chosen_texture_reg   <= '0;
            column_texel_reg     <= '0;
            held_line_height_reg <= LH_W'(1);
            current_row_reg      <= '0;
            final_row_reg        <= '0;
            span_active_reg      <= 1'b0;
        end else begin
            if (s_fire && (s_tuser == OP_SETUP)) begin
                active_column_reg    <= in_column;
                chosen_texture_reg   <= sel;
                held_line_height_reg <= (in_lh == '0) ? LH_W'(1) : in_lh;
                current_row_reg      <= in_s0;
                final_row_reg        <= s1_sat;
                span_active_reg      <= (in_s0 <= s1_sat)
                                     && ({3'b0, in_column} < 13'(SCREEN_WIDTH));
            end else if (row_fire) begin
                if (q_job.last) begin
                    span_active_reg <= 1'b0;
                end else begin
                    current_row_reg <= current_row_reg + 1'b1;
                end
            end
            if (state_reg == F_FIN) begin
                column_texel_reg <= tx_fin[COORD_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && (s_tuser == OP_SETUP)) begin
            dist_reg   <= in_dist;
            ray_reg    <= in_side ? in_rx : in_ry;
            pos_lo_reg <= in_side ? in_px[FRAC_BITS-1:0] : in_py[FRAC_BITS-1:0];
            w_reg      <= tex_dim(tex_w_reg[sel]);
            mirror_reg <= mirror;
        end
        if (state_reg == F_MUL) begin
            prod_reg <= product[2*FRAC_BITS-1:0];
        end
        if (state_reg == F_ADD) begin
            wall_reg <= prod_reg + {pos_lo_reg, {FRAC_BITS{1'b0}}};
        end
        if (state_reg == F_SCALE) begin
            tx_raw_reg <= scaled[2*FRAC_BITS+COORD_W-1:2*FRAC_BITS];
        end
    end

endmodule

// ----- rtl/core/twc_back.sv -----
`timescale 1ns / 1ps
// Back part: texel row by multiply and radix-2 division, then the output register.
// Depends on twc_pkg; drains twc_queue.
module twc_back import twc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    output logic                 q_pop,
    input  job_t                 q_job,
    input  logic                 q_empty,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    b_state_t state_reg, state_next;

    job_t                 job_reg;
    logic [NUM_W-1:0]     num_reg;
    logic                 neg_reg;
    logic [REM_W-1:0]     rem_reg;
    logic [DIV_STEPS-1:0] nlo_reg;
    logic [DIV_STEPS-1:0] quo_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [COORD_W-1:0]   ty_reg;

    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic                 out_last_reg;

    logic                 load_out;
    logic                 over;
    logic [REM_W:0]       trial;
    logic [REM_W:0]       divisor;
    logic                 fits;
    logic [TEX_DIM_W-1:0] th_m1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    assign th_m1   = job_reg.tex_h - 1'b1;
    assign over    = num_reg >= (NUM_W'(job_reg.line_h) << (8 + DIV_STEPS));
    assign trial   = {rem_reg, nlo_reg[DIV_STEPS-1]};
    assign divisor = (REM_W+1)'({job_reg.line_h, 8'b0});
    assign fits    = trial >= divisor;

    always_comb begin
        state_next = state_reg;
        q_pop      = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            B_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    state_next = B_MUL;
                end
            end
            B_MUL: state_next = B_CHK;
            B_CHK: begin
                if (neg_reg || over) begin
                    state_next = B_OUT;
                end else begin
                    state_next = B_DIV;
                end
            end
            B_DIV: begin
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = B_CLAMP;
                end
            end
            B_CLAMP: state_next = B_OUT;
            B_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    load_out   = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            job_reg <= q_job;
        end
        case (state_reg)
            B_MUL: begin
                num_reg <= NUM_W'(job_reg.row_off[MAG_W-1:0]) * NUM_W'(job_reg.tex_h);
                neg_reg <= job_reg.row_off[ROW_OFF_W-1];
            end
            B_CHK: begin
                rem_reg <= num_reg[NUM_W-1:DIV_STEPS];
                nlo_reg <= num_reg[DIV_STEPS-1:0];
                quo_reg <= '0;
                cnt_reg <= CNT_W'(DIV_STEPS);
                if (neg_reg) begin
                    ty_reg <= '0;
                end else begin
                    ty_reg <= th_m1[COORD_W-1:0];
                end
            end
            B_DIV: begin
                rem_reg <= fits ? REM_W'(trial - divisor) : trial[REM_W-1:0];
                quo_reg <= {quo_reg[DIV_STEPS-2:0], fits};
                nlo_reg <= nlo_reg << 1;
                cnt_reg <= cnt_reg - 1'b1;
            end
            B_CLAMP: begin
                ty_reg <= (quo_reg >= job_reg.tex_h) ? th_m1[COORD_W-1:0]
                                                     : quo_reg[COORD_W-1:0];
            end
            default: begin
            end
        endcase
        if (load_out) begin
            out_data_reg <= {6'b0, ty_reg, job_reg.texel_x, job_reg.tex_sel,
                             job_reg.screen_y, job_reg.screen_x};
            out_last_reg <= job_reg.last;
        end
    end

endmodule

// ----- rtl/core/textured_wall_column_texel_gen.sv -----
`timescale 1ns / 1ps
// Top level of the raycaster wall column texel generator.
// Depends on twc_pkg, twc_front, twc_queue and twc_back.
//
// Usage:
//   Input items arrive on s_t*: s_tuser is the opcode (0 column setup, 1 row
//   tick). A setup item latches the column, picks the wall texture and forms
//   the texel column; it yields no output. Each row tick with a span active
//   yields one output item on m_t* carrying screen x/y, texture select and
//   texel x/y; m_tlast marks the last row of the span. A row tick with no
//   span active yields nothing.
//   Texture sizes are written on the cfg_* channel (index 0..7: west width,
//   west height, east, north, south likewise); write only while idle.
// Flow:
//   A setup item occupies the front through its multiply, add, scale and
//   mirror steps. A row tick is taken and queued while the front is idle
//   and the queue has room. The back works on one row at a time, using the
//   11-step radix-2 division for the texel row, and pops the next row only once the last is in the output register.
//   A two-entry queue sits between front and back.
// Reset (aresetn low, synchronous) clears the span, restores all texture
// sizes to 64 and empties the queue and output register. When the receiver
// holds m_tready low, the output register holds its item, the back waits,
// and the front keeps taking row ticks until the queue fills.
module textured_wall_column_texel_gen import twc_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // column[9:0] hit_side[10] ray_x[31:11] ray_y[52:32] player_x[76:53]
    // player_y[100:77] wall_distance[124:101] line_h[140:125]
    // span_start[150:141] span_end[160:151], zero fill above
    input  logic [S_TDATA_W-1:0] s_tdata,
    // opcode[0]
    input  logic                 s_tuser,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TEX_DIM_W-1:0] cfg_data,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // screen_x[9:0] screen_y[19:10] texture_select[21:20] texel_x[31:22]
    // texel_y[41:32], zero fill above
    output logic [M_TDATA_W-1:0] m_tdata,
    output logic                 m_tlast
);

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    job_t push_job;
    job_t pop_job;

    twc_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_push    (q_push),
        .q_job     (push_job),
        .q_full    (q_full)
    );

    twc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    twc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_pop    (q_pop),
        .q_job    (pop_job),
        .q_empty  (q_empty),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    a_setup_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == OP_SETUP)) |=> !s_tready)
        else $error("front took an item during column setup");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("row job pushed into a full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_empty)
        else $error("row job popped from an empty queue");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:42] == '0))
        else $error("output fill bits not zero");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for textured_wall_column_texel_gen: column setups and row ticks
// in, texel pixels out, checked against an in-bench column model. Depends on twc_pkg.
module testbench;
    import twc_pkg::*;

    localparam int REG_WEST_WIDTH   = 0;
    localparam int REG_WEST_HEIGHT  = 1;
    localparam int REG_EAST_WIDTH   = 2;
    localparam int REG_EAST_HEIGHT  = 3;
    localparam int REG_NORTH_WIDTH  = 4;
    localparam int REG_NORTH_HEIGHT = 5;
    localparam int REG_SOUTH_WIDTH  = 6;
    localparam int REG_SOUTH_HEIGHT = 7;

    localparam int MAX_IDLE        = 14;
    localparam int SETTLE_CYCLES   = 40;
    localparam int STALL_LIMIT     = 4000;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int MAX_REPORTS     = 10;

    typedef struct {
        logic [COORD_W-1:0] column;
        logic               hit_side;
        logic [RAY_W-1:0]   ray_x;
        logic [RAY_W-1:0]   ray_y;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [DIST_W-1:0]  wall_dist;
        logic [LH_W-1:0]    line_h;
        logic [COORD_W-1:0] row_first;
        logic [COORD_W-1:0] row_last;
    } column_setup_t;

    typedef struct packed {
        logic [COORD_W-1:0] screen_x;
        logic [COORD_W-1:0] screen_y;
        logic [1:0]         tex_sel;
        logic [COORD_W-1:0] texel_x;
        logic [COORD_W-1:0] texel_y;
        logic               last_row;
    } pixel_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TEX_DIM_W-1:0] cfg_data;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    // column model state
    logic [TEX_DIM_W-1:0] tex_size [8];
    logic [COORD_W-1:0]   cm_column;
    logic [1:0]           cm_tex;
    logic [COORD_W-1:0]   cm_texel_x;
    logic [LH_W-1:0]      cm_line_h;
    logic [COORD_W-1:0]   cm_row;
    logic [COORD_W-1:0]   cm_final_row;
    logic                 cm_span_on;

    pixel_t pending_pixels[$];

    bit tx_idle;
    bit rx_idle;
    bit m_took;
    int rx_wait;
    int rx_hold_cycles;
    int stall_cycles;
    int error_count;
    int items_sent;
    int setups_sent;
    int ticks_sent;
    int pixels_checked;
    int cfg_writes;

    textured_wall_column_texel_gen dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic int unsigned effective_dim(input logic [TEX_DIM_W-1:0] v);
        if (v == 0) return 1;
        if (v > TEX_DIM_MAX) return TEX_DIM_MAX;
        return v;
    endfunction

    function automatic logic [S_TDATA_W-1:0] pack_setup(input column_setup_t c);
        return S_TDATA_W'({c.row_last, c.row_first, c.line_h, c.wall_dist, c.pos_y, c.pos_x,
                           c.ray_y, c.ray_x, c.hit_side, c.column});
    endfunction

    function automatic logic [S_TDATA_W-1:0] noise_bits();
        return S_TDATA_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    endfunction

    function automatic column_setup_t make_setup(
        input logic [COORD_W-1:0] column, input logic side,
        input logic [RAY_W-1:0] rx, input logic [RAY_W-1:0] ry,
        input logic [POS_W-1:0] px, input logic [POS_W-1:0] py,
        input logic [DIST_W-1:0] wd, input logic [LH_W-1:0] lh,
        input logic [COORD_W-1:0] r0, input logic [COORD_W-1:0] r1);
        column_setup_t c;
        c.column = column;
        c.hit_side = side;
        c.ray_x = rx;
        c.ray_y = ry;
        c.pos_x = px;
        c.pos_y = py;
        c.wall_dist = wd;
        c.line_h = lh;
        c.row_first = r0;
        c.row_last = r1;
        return c;
    endfunction

    function automatic logic [RAY_W-1:0] rand_ray();
        case ($urandom_range(0, 5))
            0: return RAY_W'($urandom);
            1: return '0;
            default: return RAY_W'($urandom_range(0, 2 * 131072) - 131072);
        endcase
    endfunction

    function automatic logic [TEX_DIM_W-1:0] rand_tex_dim();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return TEX_DIM_W'(1);
            2: return TEX_DIM_W'(TEX_DIM_MAX);
            3: return TEX_DIM_W'($urandom_range(TEX_DIM_MAX + 1, 2047));
            4: return TEX_DIM_W'($urandom_range(0, 2047));
            default: return TEX_DIM_W'($urandom_range(2, 256));
        endcase
    endfunction

    function automatic column_setup_t rand_setup_any();
        column_setup_t c;
        c.column = COORD_W'($urandom);
        c.hit_side = $urandom_range(0, 1);
        c.ray_x = rand_ray();
        c.ray_y = rand_ray();
        c.pos_x = POS_W'($urandom);
        c.pos_y = POS_W'($urandom);
        c.wall_dist = ($urandom_range(0, 1) == 0) ? DIST_W'($urandom) : DIST_W'($urandom_range(0, 1 << 20));
        case ($urandom_range(0, 7))
            0: c.line_h = '0;
            1: c.line_h = LH_W'($urandom);
            2: c.line_h = LH_W'($urandom_range(1, 16));
            default: c.line_h = LH_W'($urandom_range(17, 2048));
        endcase
        c.row_first = COORD_W'($urandom);
        c.row_last = COORD_W'($urandom);
        return c;
    endfunction

    // Place a short span somewhere on the wall so texel rows move through the texture.
    function automatic column_setup_t rand_wall_setup();
        column_setup_t c;
        int top;
        int r0;
        int r1;
        c = rand_setup_any();
        top = SCREEN_HEIGHT / 2 - int'(c.line_h) / 2;
        if (top < 0) top = 0;
        r0 = top + $urandom_range(0, int'(c.line_h));
        if (r0 > SCREEN_HEIGHT - 1) r0 = $urandom_range(0, SCREEN_HEIGHT - 1);
        r1 = r0 + $urandom_range(0, 11);
        if (r1 > SCREEN_HEIGHT - 1) r1 = SCREEN_HEIGHT - 1;
        c.row_first = COORD_W'(r0);
        c.row_last = COORD_W'(r1);
        return c;
    endfunction

    function automatic int span_rows(input column_setup_t c);
        return (c.row_first <= c.row_last) ? int'(c.row_last) - int'(c.row_first) + 1 : 0;
    endfunction

    task automatic flag_error(input string what);
        error_count++;
        if (error_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $time, what);
    endtask

    task automatic column_model_step(input logic op, input logic [S_TDATA_W-1:0] d);
        logic signed [RAY_W-1:0] rx;
        logic signed [RAY_W-1:0] ry;
        logic [1:0]              sel;
        logic [63:0]             hit;
        logic [63:0]             scaled;
        longint                  prod;
        longint                  offs;
        longint                  th;
        longint                  ty;
        int unsigned             w;
        int unsigned             tx;
        logic                    mirror;
        pixel_t                  p;
        if (op == OP_SETUP) begin
            rx = d[31:11];
            ry = d[52:32];
            if (d[10] == 1'b0) sel = (rx < 0) ? TEX_WEST : TEX_EAST;
            else sel = (ry < 0) ? TEX_NORTH : TEX_SOUTH;
            prod = longint'(d[124:101]) * (d[10] ? longint'(rx) : longint'(ry));
            hit = ((d[10] ? 64'(d[76:53]) : 64'(d[100:77])) << FRAC_BITS) + 64'(prod);
            w = effective_dim(tex_size[2 * sel]);
            scaled = 64'(hit[2*FRAC_BITS-1:0]) * 64'(w);
            tx = scaled >> (2 * FRAC_BITS);
            mirror = (!d[10] && rx < 0) || (d[10] && ry > 0);
            if (mirror) tx = w - tx - 1;
            if (tx >= w) tx = w - 1;
            cm_column = d[9:0];
            cm_tex = sel;
            cm_texel_x = COORD_W'(tx);
            cm_line_h = (d[140:125] == 0) ? LH_W'(1) : d[140:125];
            cm_row = d[150:141];
            cm_final_row = d[160:151];
            cm_span_on = (d[150:141] <= d[160:151]);
        end else if (cm_span_on) begin
            th = effective_dim(tex_size[2 * cm_tex + 1]);
            offs = longint'(cm_row) * 256 - longint'(SCREEN_HEIGHT) * 128
                   + longint'(cm_line_h) * 128;
            ty = ((offs * th) / longint'(cm_line_h)) / 256;
            if (ty < 0) ty = 0;
            else if (ty >= th) ty = th - 1;
            p.screen_x = cm_column;
            p.screen_y = cm_row;
            p.tex_sel = cm_tex;
            p.texel_x = cm_texel_x;
            p.texel_y = COORD_W'(ty);
            p.last_row = (cm_row >= cm_final_row);
            pending_pixels.push_back(p);
            if (p.last_row) cm_span_on = 1'b0;
            else cm_row = cm_row + 1'b1;
        end
    endtask

    task automatic push_item(input logic op, input logic [S_TDATA_W-1:0] data);
        int gap;
        gap = tx_idle ? $urandom_range(0, MAX_IDLE) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= data;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        if (op == OP_SETUP) setups_sent++;
        else ticks_sent++;
        column_model_step(op, data);
    endtask

    task automatic run_column(input column_setup_t c, input int ticks);
        push_item(OP_SETUP, pack_setup(c));
        repeat (ticks) push_item(OP_ROW, noise_bits());
    endtask

    // Drop valid, drain every expected pixel, then let the front finish any setup.
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_tex_reg(input int idx, input logic [TEX_DIM_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_IDX_W'(idx);
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        tex_size[idx] = val;
        cfg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_tex_sizes(
        input logic [TEX_DIM_W-1:0] ww, input logic [TEX_DIM_W-1:0] wh,
        input logic [TEX_DIM_W-1:0] ew, input logic [TEX_DIM_W-1:0] eh,
        input logic [TEX_DIM_W-1:0] nw, input logic [TEX_DIM_W-1:0] nh,
        input logic [TEX_DIM_W-1:0] sw, input logic [TEX_DIM_W-1:0] sh);
        wait_idle();
        write_tex_reg(REG_WEST_WIDTH, ww);
        write_tex_reg(REG_WEST_HEIGHT, wh);
        write_tex_reg(REG_EAST_WIDTH, ew);
        write_tex_reg(REG_EAST_HEIGHT, eh);
        write_tex_reg(REG_NORTH_WIDTH, nw);
        write_tex_reg(REG_NORTH_HEIGHT, nh);
        write_tex_reg(REG_SOUTH_WIDTH, sw);
        write_tex_reg(REG_SOUTH_HEIGHT, sh);
    endtask

    task automatic test_directed_columns();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        push_item(OP_ROW, noise_bits());
        run_column(make_setup(0, 1'b0, -65536, 30000, 24'h010000, 24'h028000, 24'h018000,
                              1024, 0, 1), 2);
        run_column(make_setup(1023, 1'b0, 0, -1048576, 0, 24'hFFFFFF, 24'hFFFFFF,
                              0, 511, 512), 3);
        run_column(make_setup(512, 1'b1, 1048575, -1, 24'hFFFFFF, 0, 24'hFFFFFF,
                              65535, 1023, 1023), 1);
        run_column(make_setup(7, 1'b1, -1048576, 1048575, 24'h123456, 24'h654321, 24'h000100,
                              300, 5, 3), 1);
        run_column(make_setup(100, 1'b1, 70000, 0, 24'h0A0000, 24'h050000, 24'h020000,
                              64, 100, 110), 2);
        run_column(make_setup(200, 1'b0, 1, 50000, 24'h7FFFFF, 24'h800000, 24'h00FFFF,
                              1, 0, 1023), 3);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        run_column(make_setup(900, 1'b1, -40000, 90000, 24'h030000, 24'h030000, 24'h024000,
                              2048, 510, 514), 5);
    endtask

    task automatic test_texture_size_extremes();
        column_setup_t c;
        for (int s = 0; s < 5; s++) begin
            case (s)
                0: set_tex_sizes(1, 1, 1, 1, 1, 1, 1, 1);
                1: set_tex_sizes(1024, 1024, 1024, 1024, 1024, 1024, 1024, 1024);
                2: set_tex_sizes(0, 0, 0, 0, 0, 0, 0, 0);
                3: set_tex_sizes(2047, 2047, 2047, 2047, 2047, 2047, 2047, 2047);
                default: set_tex_sizes(1025, 3, 7, 1000, 513, 2, 64, 1023);
            endcase
            tx_idle = (s % 2 == 0);
            rx_idle = (s % 2 == 1);
            for (int f = 0; f < 4; f++) begin
                c = rand_wall_setup();
                c.hit_side = (f >= 2);
                if (f == 0) c.ray_x[RAY_W-1] = 1'b1;
                if (f == 1) c.ray_x[RAY_W-1] = 1'b0;
                if (f == 2) c.ray_y[RAY_W-1] = 1'b1;
                if (f == 3) c.ray_y[RAY_W-1] = 1'b0;
                run_column(c, span_rows(c));
            end
        end
    endtask

    task automatic test_stalled_receiver();
        column_setup_t c;
        wait_idle();
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        c = rand_wall_setup();
        c.line_h = 700;
        c.row_first = 200;
        c.row_last = 239;
        push_item(OP_SETUP, pack_setup(c));
        rx_hold_cycles = HOLD_OFF_CYCLES;
        repeat (40) push_item(OP_ROW, noise_bits());
    endtask

    task automatic test_random_columns(input int phases, input int items_per_phase);
        column_setup_t c;
        int goal;
        for (int p = 0; p < phases; p++) begin
            set_tex_sizes(rand_tex_dim(), rand_tex_dim(), rand_tex_dim(), rand_tex_dim(),
                          rand_tex_dim(), rand_tex_dim(), rand_tex_dim(), rand_tex_dim());
            goal = items_sent + items_per_phase;
            while (items_sent < goal) begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
                case ($urandom_range(0, 9))
                    0: repeat ($urandom_range(1, 3)) push_item(OP_ROW, noise_bits());
                    1: run_column(rand_setup_any(), $urandom_range(0, 6));
                    2: begin
                        c = rand_wall_setup();
                        run_column(c, $urandom_range(0, span_rows(c)));
                    end
                    default: begin
                        c = rand_wall_setup();
                        run_column(c, span_rows(c) + $urandom_range(0, 1));
                    end
                endcase
            end
        end
    endtask

    // receiver: per-item random wait plus an optional long hold-off
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (m_took) begin
                m_took = 1'b0;
                rx_wait = rx_idle ? $urandom_range(0, MAX_IDLE) : 0;
            end
            if (rx_hold_cycles > 0) begin
                rx_hold_cycles--;
                m_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        pixel_t got;
        pixel_t want;
        if (aresetn && m_tvalid && m_tready) begin
            m_took = 1'b1;
            got.screen_x = m_tdata[9:0];
            got.screen_y = m_tdata[19:10];
            got.tex_sel = m_tdata[21:20];
            got.texel_x = m_tdata[31:22];
            got.texel_y = m_tdata[41:32];
            got.last_row = m_tlast;
            if (pending_pixels.size() == 0) begin
                flag_error($sformatf("unexpected pixel x=%0d y=%0d tex=%0d tx=%0d ty=%0d last=%0d",
                    got.screen_x, got.screen_y, got.tex_sel, got.texel_x, got.texel_y,
                    got.last_row));
            end else begin
                want = pending_pixels.pop_front();
                pixels_checked++;
                if (got.screen_x !== want.screen_x || got.screen_y !== want.screen_y ||
                    got.tex_sel !== want.tex_sel || got.texel_x !== want.texel_x ||
                    got.texel_y !== want.texel_y || got.last_row !== want.last_row) begin
                    flag_error($sformatf(
                        "pixel expected x=%0d y=%0d tex=%0d tx=%0d ty=%0d last=%0d, got x=%0d y=%0d tex=%0d tx=%0d ty=%0d last=%0d",
                        want.screen_x, want.screen_y, want.tex_sel, want.texel_x,
                        want.texel_y, want.last_row, got.screen_x, got.screen_y,
                        got.tex_sel, got.texel_x, got.texel_y, got.last_row));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = OP_SETUP;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        for (int i = 0; i < 8; i++) tex_size[i] = TEX_DIM_W'(64);
        cm_column = '0;
        cm_tex = TEX_WEST;
        cm_texel_x = '0;
        cm_line_h = LH_W'(1);
        cm_row = '0;
        cm_final_row = '0;
        cm_span_on = 1'b0;
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        m_took = 1'b0;
        rx_wait = 0;
        rx_hold_cycles = 0;
        stall_cycles = 0;
        error_count = 0;
        items_sent = 0;
        setups_sent = 0;
        ticks_sent = 0;
        pixels_checked = 0;
        cfg_writes = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_columns();
        test_texture_size_extremes();
        test_stalled_receiver();
        test_random_columns(5, 130);
        wait_idle();

        $display("Run covered %0d items (%0d column setups, %0d row ticks) and %0d texture size writes,",
                 items_sent, setups_sent, ticks_sent, cfg_writes);
        $display("with %0d pixels checked across all four faces and a %0d-cycle output stall.",
                 pixels_checked, HOLD_OFF_CYCLES);
        if (error_count == 0 && pending_pixels.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
